[rtl/rhec_pkg.sv]
`default_nettype none

package rhec_pkg;

   localparam int CACHE_ENTRIES = 32;
   localparam int MAX_RESULTS = 32;
   localparam int IDX_W = $clog2(CACHE_ENTRIES);
   localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
   localparam int WB_W = $clog2(MAX_RESULTS + 1);
   localparam int OBJ_W = 32;
   localparam int SLOT_W = 5;
   localparam int REFS_W = 16;
   localparam int KIND_W = 2;
   localparam int CODE_W = 3;
   localparam int TOTAL_W = 32;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [WB_W-1:0] wb_type;
   typedef logic [OBJ_W-1:0] obj_type;
   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [REFS_W-1:0] refs_type;
   typedef logic [TOTAL_W-1:0] total_type;

   localparam obj_type INVALID_MARKER = obj_type'(1);
   localparam refs_type REFS_MAX = '1;

   typedef enum logic [KIND_W-1:0] {
      KIND_REQUEST,
      KIND_RELEASE,
      KIND_MARK,
      KIND_FLUSH
   } kind_type;

   typedef enum logic [CODE_W-1:0] {
      RC_HIT,
      RC_MISS,
      RC_FAIL,
      RC_WRITEBACK,
      RC_LOAD,
      RC_DELETE,
      RC_ACK
   } code_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_INSTALL,
      WR_HIT,
      WR_DEC,
      WR_DIRTY
   } wr_type;

   typedef enum logic [1:0] {
      OS_ENT,
      OS_REQ,
      OS_ZERO
   } slot_sel_type;

   typedef enum logic [1:0] {
      OO_ENT,
      OO_REQ,
      OO_HELD,
      OO_ZERO
   } obj_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_FAIL,
      ST_PROBE,
      ST_HIT,
      ST_MISS_WB,
      ST_MISS_LOAD,
      ST_MISS_DONE,
      ST_SLOT_CAP,
      ST_SLOT_ACT,
      ST_FLUSH,
      ST_FLUSH_END
   } state_type;

   typedef struct packed {
      obj_type  obj;
      refs_type refs;
      logic     dirty;
   } entry_type;

   typedef struct packed {
      logic         accept;
      logic         scan_start;
      logic         scan_home;
      logic         step;
      logic         consume;
      logic         capture;
      logic         set_free;
      logic         wb_inc;
      logic         rd_slot;
      logic         cnt_hit;
      logic         cnt_miss;
      wr_type       wr_op;
      logic         invalidate;
      logic         emit;
      code_type     code;
      slot_sel_type slot_sel;
      obj_sel_type  obj_sel;
      logic         last;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     rejected;
      logic     slot_ok;
      logic     gone;
      logic     look;
      logic     match;
      logic     cur_free;
      logic     cur_dirty;
      logic     free_found;
      logic     scan_left;
      logic     pend;
      logic     wb_full;
      logic     ent_dirty;
      logic     ent_valid;
      logic     ent_refs_nz;
      logic     ent_refs_one;
      logic     out_free;
   } status_type;

endpackage

`default_nettype wire

[rtl/rhec_req_if.sv]
`default_nettype none

interface rhec_req_if;
   logic                   valid;
   logic                   ready;
   logic [rhec_pkg::KIND_W-1:0] kind;
   rhec_pkg::obj_type      object_number;
   logic                   for_write;
   rhec_pkg::slot_type     slot;
   logic                   links_gone;

   modport source (
      output valid, kind, object_number, for_write, slot, links_gone,
      input  ready
   );

   modport sink (
      input  valid, kind, object_number, for_write, slot, links_gone,
      output ready
   );
endinterface

`default_nettype wire

[rtl/rhec_rsp_if.sv]
`default_nettype none

interface rhec_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [rhec_pkg::CODE_W-1:0] result_code;
   rhec_pkg::slot_type          out_slot;
   rhec_pkg::obj_type           out_object;
   logic                        last;
   rhec_pkg::total_type         hit_total;
   rhec_pkg::total_type         miss_total;

   modport source (
      output valid, result_code, out_slot, out_object, last, hit_total, miss_total,
      input  ready
   );

   modport sink (
      input  valid, result_code, out_slot, out_object, last, hit_total, miss_total,
      output ready
   );
endinterface

`default_nettype wire

[rtl/refcounted_hashed_entry_cache_core.sv]
// Reference-counted object cache, linearly probed table of CACHE_ENTRIES slots.
// req_ch takes one word at a time: request, release, mark dirty or flush.
// rsp_ch returns one to MAX_RESULTS words per request word; the final word
// of each carries last, and every word carries the hit and miss totals.
// A request walks the table one slot a cycle from its home slot through the
// single read port of the entry RAM. A hit stops the walk at the matching
// slot, a miss or a full table walks every slot, and a rejected number skips
// the walk. Release and mark dirty read only the named slot; a flush walks
// the table from slot 0, its writeback words leaving during the walk. req_ch
// is ready again once the last word of the previous request word sits in the
// result register, so one word is handled at a time, paced by the slot walk.
// Reset is synchronous; it empties the table at once (per-slot valid flags)
// and clears both totals, so no clearing pass follows.
// A stalled rsp_ch holds its word; the engine waits before each further word
// and resumes without loss when the receiver takes it.
`default_nettype none

module refcounted_hashed_entry_cache_core (
   input wire logic    clock,
   input wire logic    reset,
   rhec_req_if.sink    req_ch,
   rhec_rsp_if.source  rsp_ch
);

   rhec_pkg::cmd_type    cmd;
   rhec_pkg::status_type status;

   rhec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rhec_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_kind          (req_ch.kind),
      .req_object_number (req_ch.object_number),
      .req_slot          (req_ch.slot),
      .req_links_gone    (req_ch.links_gone),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_result_code   (rsp_ch.result_code),
      .rsp_out_slot      (rsp_ch.out_slot),
      .rsp_out_object    (rsp_ch.out_object),
      .rsp_last          (rsp_ch.last),
      .rsp_hit_total     (rsp_ch.hit_total),
      .rsp_miss_total    (rsp_ch.miss_total)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("word accepted while a previous one is in work");

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result register overwritten before it was taken");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> status.scan_left)
      else $error("slot walk ran past the table");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && cmd.last |=> req_ch.ready)
      else $error("not ready after the last word of a request");

endmodule

`default_nettype wire

[rtl/rhec_ram.sv]
`default_nettype none

module rhec_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/rhec_dp.sv]
`default_nettype none

module rhec_dp (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire rhec_pkg::cmd_type           cmd,
   output rhec_pkg::status_type             status,
   input  wire logic [rhec_pkg::KIND_W-1:0] req_kind,
   input  wire rhec_pkg::obj_type           req_object_number,
   input  wire rhec_pkg::slot_type          req_slot,
   input  wire logic                        req_links_gone,
   input  wire logic                        rsp_ready,
   output logic                             rsp_valid,
   output logic [rhec_pkg::CODE_W-1:0]      rsp_result_code,
   output rhec_pkg::slot_type               rsp_out_slot,
   output rhec_pkg::obj_type                rsp_out_object,
   output logic                             rsp_last,
   output rhec_pkg::total_type              rsp_hit_total,
   output rhec_pkg::total_type              rsp_miss_total
);

   // captured word
   logic [rhec_pkg::KIND_W-1:0] kind_ff;
   rhec_pkg::obj_type           obj_ff;
   rhec_pkg::slot_type          slot_ff;
   logic                        gone_ff;

   // table and scan state
   logic [rhec_pkg::CACHE_ENTRIES-1:0] valid_ff;
   rhec_pkg::idx_type   addr_ff;
   rhec_pkg::idx_type   rd_idx_ff;
   rhec_pkg::idx_type   ent_slot_ff;
   rhec_pkg::cnt_type   cnt_ff;
   rhec_pkg::wb_type    wb_cnt_ff;
   logic                look_ff;
   logic                rd_v_ff;
   logic                free_found_ff;
   rhec_pkg::entry_type ent_ff;
   rhec_pkg::total_type hit_cnt_ff;
   rhec_pkg::total_type miss_cnt_ff;

   // result register
   logic                rsp_valid_ff;
   rhec_pkg::code_type  code_ff;
   rhec_pkg::slot_type  out_slot_ff;
   rhec_pkg::obj_type   out_obj_ff;
   logic                last_ff;
   rhec_pkg::total_type hit_tot_ff;
   rhec_pkg::total_type miss_tot_ff;

   rhec_pkg::entry_type rd_word;
   rhec_pkg::entry_type cur;
   rhec_pkg::entry_type wr_word;
   rhec_pkg::idx_type   home;
   rhec_pkg::idx_type   slot_idx;
   rhec_pkg::idx_type   addr_next;
   rhec_pkg::idx_type   rd_addr;
   logic                rd_en;
   logic                wr_en;
   logic                slot_ok;
   rhec_pkg::obj_type   held;
   rhec_pkg::slot_type  slot_mux;
   rhec_pkg::obj_type   obj_mux;

   rhec_ram #(
      .WIDTH ($bits(rhec_pkg::entry_type)),
      .DEPTH (rhec_pkg::CACHE_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ent_slot_ff),
      .wr_data (wr_word),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign home = rhec_pkg::idx_type'(obj_ff);
   assign slot_idx = rhec_pkg::idx_type'(slot_ff);
   assign slot_ok = (int'(slot_ff) < rhec_pkg::CACHE_ENTRIES);
   assign addr_next = (addr_ff == rhec_pkg::idx_type'(rhec_pkg::CACHE_ENTRIES - 1)) ?
                      '0 : addr_ff + 1'b1;
   assign rd_en = cmd.step | cmd.rd_slot;
   assign rd_addr = cmd.rd_slot ? slot_idx : addr_ff;
   assign wr_en = (cmd.wr_op != rhec_pkg::WR_NONE);
   assign held = slot_ok ? ent_ff.obj : '0;

   // entries never written read as empty
   always_comb begin
      cur.obj = rd_v_ff ? rd_word.obj : rhec_pkg::INVALID_MARKER;
      cur.refs = rd_v_ff ? rd_word.refs : '0;
      cur.dirty = rd_v_ff & rd_word.dirty;
   end

   always_comb begin
      wr_word = ent_ff;
      case (cmd.wr_op)
         rhec_pkg::WR_INSTALL: begin
            wr_word.obj = obj_ff;
            wr_word.refs = rhec_pkg::refs_type'(1);
            wr_word.dirty = 1'b0;
         end
         rhec_pkg::WR_HIT: begin
            if (ent_ff.refs != rhec_pkg::REFS_MAX) begin
               wr_word.refs = ent_ff.refs + 1'b1;
            end
         end
         rhec_pkg::WR_DEC: begin
            wr_word.refs = ent_ff.refs - 1'b1;
         end
         rhec_pkg::WR_DIRTY: begin
            wr_word.dirty = 1'b1;
         end
         default: begin
            wr_word = ent_ff;
         end
      endcase
   end

   always_comb begin
      case (cmd.slot_sel)
         rhec_pkg::OS_ENT: slot_mux = rhec_pkg::slot_type'(ent_slot_ff);
         rhec_pkg::OS_REQ: slot_mux = slot_ff;
         default:          slot_mux = '0;
      endcase
      case (cmd.obj_sel)
         rhec_pkg::OO_ENT:  obj_mux = ent_ff.obj;
         rhec_pkg::OO_REQ:  obj_mux = obj_ff;
         rhec_pkg::OO_HELD: obj_mux = held;
         default:           obj_mux = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         cnt_ff <= '0;
         wb_cnt_ff <= '0;
         look_ff <= 1'b0;
         free_found_ff <= 1'b0;
         hit_cnt_ff <= '0;
         miss_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.wr_op == rhec_pkg::WR_INSTALL) begin
            valid_ff[ent_slot_ff] <= 1'b1;
         end
         if (cmd.invalidate) begin
            valid_ff[ent_slot_ff] <= 1'b0;
         end
         if (cmd.scan_start) begin
            cnt_ff <= '0;
            wb_cnt_ff <= '0;
            look_ff <= 1'b0;
            free_found_ff <= 1'b0;
         end else begin
            if (cmd.step) begin
               cnt_ff <= cnt_ff + 1'b1;
            end
            if (cmd.wb_inc) begin
               wb_cnt_ff <= wb_cnt_ff + 1'b1;
            end
            if (cmd.set_free) begin
               free_found_ff <= 1'b1;
            end
            look_ff <= cmd.step | (look_ff & ~cmd.consume);
         end
         if (cmd.cnt_hit) begin
            hit_cnt_ff <= hit_cnt_ff + 1'b1;
         end
         if (cmd.cnt_miss) begin
            miss_cnt_ff <= miss_cnt_ff + 1'b1;
         end
         rsp_valid_ff <= cmd.emit | (rsp_valid_ff & ~rsp_ready);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff <= req_kind;
         obj_ff <= req_object_number;
         slot_ff <= req_slot;
         gone_ff <= req_links_gone;
      end
      if (cmd.scan_start) begin
         addr_ff <= cmd.scan_home ? home : '0;
      end else if (cmd.step) begin
         addr_ff <= addr_next;
      end
      if (rd_en) begin
         rd_idx_ff <= rd_addr;
         rd_v_ff <= valid_ff[rd_addr];
      end
      if (cmd.capture) begin
         ent_ff <= cur;
         ent_slot_ff <= rd_idx_ff;
      end
      if (cmd.emit) begin
         code_ff <= cmd.code;
         out_slot_ff <= slot_mux;
         out_obj_ff <= obj_mux;
         last_ff <= cmd.last;
         hit_tot_ff <= hit_cnt_ff;
         miss_tot_ff <= miss_cnt_ff;
      end
   end

   always_comb begin
      status.kind = rhec_pkg::kind_type'(kind_ff);
      status.rejected = (obj_ff <= rhec_pkg::INVALID_MARKER);
      status.slot_ok = slot_ok;
      status.gone = gone_ff;
      status.look = look_ff;
      status.match = look_ff & rd_v_ff & (rd_word.obj == obj_ff);
      status.cur_free = ~rd_v_ff | (rd_word.refs == '0);
      status.cur_dirty = cur.dirty;
      status.free_found = free_found_ff;
      status.scan_left = (cnt_ff != rhec_pkg::cnt_type'(rhec_pkg::CACHE_ENTRIES));
      status.pend = (wb_cnt_ff != '0);
      status.wb_full = (wb_cnt_ff == rhec_pkg::wb_type'(rhec_pkg::MAX_RESULTS));
      status.ent_dirty = ent_ff.dirty;
      status.ent_valid = (ent_ff.obj != rhec_pkg::INVALID_MARKER);
      status.ent_refs_nz = (ent_ff.refs != '0);
      status.ent_refs_one = (ent_ff.refs == rhec_pkg::refs_type'(1));
      status.out_free = ~rsp_valid_ff | rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_code = code_ff;
   assign rsp_out_slot = out_slot_ff;
   assign rsp_out_object = out_obj_ff;
   assign rsp_last = last_ff;
   assign rsp_hit_total = hit_tot_ff;
   assign rsp_miss_total = miss_tot_ff;

endmodule

`default_nettype wire

[rtl/rhec_ctrl.sv]
`default_nettype none

module rhec_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire rhec_pkg::status_type status,
   output rhec_pkg::cmd_type         cmd
);

   rhec_pkg::state_type state_ff;
   rhec_pkg::state_type state_in;
   logic                scan_end;
   logic                flush_end;
   logic                flush_take;

   assign scan_end = ~status.look & ~status.scan_left;
   assign flush_end = status.wb_full | scan_end;
   // a dirty entry waits while the pending word cannot leave
   assign flush_take = status.look & (~status.cur_dirty | ~status.pend | status.out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rhec_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rhec_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = rhec_pkg::ST_DISPATCH;
            end
         end
         rhec_pkg::ST_DISPATCH: begin
            case (status.kind)
               rhec_pkg::KIND_REQUEST: begin
                  state_in = status.rejected ? rhec_pkg::ST_FAIL : rhec_pkg::ST_PROBE;
               end
               rhec_pkg::KIND_RELEASE,
               rhec_pkg::KIND_MARK: begin
                  state_in = rhec_pkg::ST_SLOT_CAP;
               end
               rhec_pkg::KIND_FLUSH: begin
                  state_in = rhec_pkg::ST_FLUSH;
               end
               default: begin
                  state_in = rhec_pkg::ST_IDLE;
               end
            endcase
         end
         rhec_pkg::ST_FAIL,
         rhec_pkg::ST_HIT,
         rhec_pkg::ST_MISS_DONE,
         rhec_pkg::ST_SLOT_ACT,
         rhec_pkg::ST_FLUSH_END: begin
            if (status.out_free) begin
               state_in = rhec_pkg::ST_IDLE;
            end
         end
         rhec_pkg::ST_PROBE: begin
            if (status.match) begin
               state_in = rhec_pkg::ST_HIT;
            end else if (scan_end) begin
               state_in = status.free_found ? rhec_pkg::ST_MISS_WB : rhec_pkg::ST_FAIL;
            end
         end
         rhec_pkg::ST_MISS_WB: begin
            if (~status.ent_dirty | status.out_free) begin
               state_in = rhec_pkg::ST_MISS_LOAD;
            end
         end
         rhec_pkg::ST_MISS_LOAD: begin
            if (status.out_free) begin
               state_in = rhec_pkg::ST_MISS_DONE;
            end
         end
         rhec_pkg::ST_SLOT_CAP: begin
            state_in = rhec_pkg::ST_SLOT_ACT;
         end
         rhec_pkg::ST_FLUSH: begin
            if (flush_end) begin
               state_in = rhec_pkg::ST_FLUSH_END;
            end
         end
         default: begin
            state_in = rhec_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         rhec_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.accept = req_valid;
         end
         rhec_pkg::ST_DISPATCH: begin
            case (status.kind)
               rhec_pkg::KIND_REQUEST: begin
                  cmd.scan_start = ~status.rejected;
                  cmd.scan_home = 1'b1;
               end
               rhec_pkg::KIND_RELEASE,
               rhec_pkg::KIND_MARK: begin
                  cmd.rd_slot = 1'b1;
               end
               rhec_pkg::KIND_FLUSH: begin
                  cmd.scan_start = 1'b1;
               end
               default: begin
                  cmd.scan_start = 1'b0;
               end
            endcase
         end
         rhec_pkg::ST_FAIL: begin
            cmd.emit = status.out_free;
            cmd.code = rhec_pkg::RC_FAIL;
            cmd.slot_sel = rhec_pkg::OS_ZERO;
            cmd.obj_sel = rhec_pkg::OO_REQ;
            cmd.last = 1'b1;
         end
         rhec_pkg::ST_PROBE: begin
            cmd.consume = status.look;
            if (status.match) begin
               cmd.capture = 1'b1;
               cmd.cnt_hit = 1'b1;
            end else begin
               if (status.look & status.cur_free & ~status.free_found) begin
                  cmd.capture = 1'b1;
                  cmd.set_free = 1'b1;
               end
               cmd.step = status.scan_left;
               cmd.cnt_miss = scan_end & status.free_found;
            end
         end
         rhec_pkg::ST_HIT: begin
            if (status.out_free) begin
               cmd.wr_op = rhec_pkg::WR_HIT;
               cmd.emit = 1'b1;
            end
            cmd.code = rhec_pkg::RC_HIT;
            cmd.slot_sel = rhec_pkg::OS_ENT;
            cmd.obj_sel = rhec_pkg::OO_REQ;
            cmd.last = 1'b1;
         end
         rhec_pkg::ST_MISS_WB: begin
            cmd.emit = status.ent_dirty & status.out_free;
            cmd.code = rhec_pkg::RC_WRITEBACK;
            cmd.slot_sel = rhec_pkg::OS_ENT;
            cmd.obj_sel = rhec_pkg::OO_ENT;
         end
         rhec_pkg::ST_MISS_LOAD: begin
            if (status.out_free) begin
               cmd.wr_op = rhec_pkg::WR_INSTALL;
               cmd.emit = 1'b1;
            end
            cmd.code = rhec_pkg::RC_LOAD;
            cmd.slot_sel = rhec_pkg::OS_ENT;
            cmd.obj_sel = rhec_pkg::OO_REQ;
         end
         rhec_pkg::ST_MISS_DONE: begin
            cmd.emit = status.out_free;
            cmd.code = rhec_pkg::RC_MISS;
            cmd.slot_sel = rhec_pkg::OS_ENT;
            cmd.obj_sel = rhec_pkg::OO_REQ;
            cmd.last = 1'b1;
         end
         rhec_pkg::ST_SLOT_CAP: begin
            cmd.capture = 1'b1;
         end
         rhec_pkg::ST_SLOT_ACT: begin
            cmd.emit = status.out_free;
            cmd.code = rhec_pkg::RC_ACK;
            cmd.slot_sel = rhec_pkg::OS_REQ;
            cmd.obj_sel = rhec_pkg::OO_HELD;
            cmd.last = 1'b1;
            if (status.out_free) begin
               if (status.kind == rhec_pkg::KIND_RELEASE) begin
                  if (status.slot_ok & status.ent_refs_nz) begin
                     if (status.ent_refs_one & status.gone) begin
                        cmd.code = rhec_pkg::RC_DELETE;
                        cmd.obj_sel = rhec_pkg::OO_ENT;
                        cmd.invalidate = 1'b1;
                     end else begin
                        cmd.wr_op = rhec_pkg::WR_DEC;
                     end
                  end
               end else if (status.slot_ok & status.ent_valid) begin
                  cmd.wr_op = rhec_pkg::WR_DIRTY;
               end
            end
         end
         rhec_pkg::ST_FLUSH: begin
            cmd.code = rhec_pkg::RC_WRITEBACK;
            cmd.slot_sel = rhec_pkg::OS_ENT;
            cmd.obj_sel = rhec_pkg::OO_ENT;
            if (~flush_end) begin
               cmd.consume = flush_take;
               cmd.capture = flush_take & status.cur_dirty;
               cmd.wb_inc = flush_take & status.cur_dirty;
               cmd.emit = flush_take & status.cur_dirty & status.pend;
               cmd.step = status.scan_left & (flush_take | ~status.look);
            end
         end
         rhec_pkg::ST_FLUSH_END: begin
            cmd.emit = status.out_free;
            cmd.last = 1'b1;
            if (status.pend) begin
               cmd.code = rhec_pkg::RC_WRITEBACK;
               cmd.slot_sel = rhec_pkg::OS_ENT;
               cmd.obj_sel = rhec_pkg::OO_ENT;
            end else begin
               cmd.code = rhec_pkg::RC_ACK;
               cmd.slot_sel = rhec_pkg::OS_ZERO;
               cmd.obj_sel = rhec_pkg::OO_ZERO;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire
